// ===== sv/srs_pkg.sv =====
// Shared types and constants for the shear, rotate and soft-clip block.
// No dependencies; imported by every module of the block.
package srs_pkg;

	// Sample word: signed 16-bit, 2048 LSB per volt.
	typedef logic signed [15:0] sample_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_ANGLE_BASE      = 3'd0,
		REG_ANGLE_CV_GAIN   = 3'd1,
		REG_SHEAR_X_BASE    = 3'd2,
		REG_SHEAR_X_CV_GAIN = 3'd3,
		REG_SHEAR_Y_BASE    = 3'd4,
		REG_SHEAR_Y_CV_GAIN = 3'd5,
		REG_PRE_X_OFFSET    = 3'd6,
		REG_PRE_Y_OFFSET    = 3'd7
	} reg_index_t;

	// Width of a rotated sum, in LSB * 2^27.
	localparam int ROT_W = 53;

	// Sine entries are Q.14 with one sign bit.
	localparam int SIN_W = 16;

endpackage

// ===== sv/srs_sine_rom.sv =====
// Constant sine lookup with two registered read ports (sine and cosine).
// Depends on srs_pkg; the entries are built at elaboration from DEPTH.
module srs_sine_rom import srs_pkg::*; #(
	parameter int DEPTH = 256
) (
	input  logic                         clk,
	input  logic [$clog2(DEPTH)-1:0]     addr_a,
	input  logic [$clog2(DEPTH)-1:0]     addr_b,
	output logic signed [SIN_W-1:0]      data_a,
	output logic signed [SIN_W-1:0]      data_b
);

	localparam logic [63:0] DEPTH_U = 64'(DEPTH);
	localparam logic [63:0] PIHALF_Q30 = 64'd1686629713;

	// Odd series up to x^11 in Q30, rounded to Q.14.
	function automatic logic signed [SIN_W-1:0] sine_entry(input int unsigned k);
		logic [63:0] a;
		logic [63:0] quad;
		logic [63:0] r;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic signed [63:0] sum;
		logic signed [63:0] mag;
		a = 64'(k) * 64'd4;
		quad = a / DEPTH_U;
		r = a % DEPTH_U;
		if (quad[0]) begin
			r = DEPTH_U - r;
		end
		x = r * PIHALF_Q30 / DEPTH_U;
		x2 = (x * x) >> 30;
		term = x;
		sum = $signed(x);
		term = ((term * x2) >> 30) / 64'd6;
		sum = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd20;
		sum = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd42;
		sum = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd72;
		sum = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd110;
		sum = sum - $signed(term);
		if (sum < 0) begin
			sum = 0;
		end
		mag = (sum + 64'sd32768) >>> 16;
		if (mag > 64'sd16384) begin
			mag = 64'sd16384;
		end
		return (quad >= 64'd2) ? SIN_W'(-mag) : SIN_W'(mag);
	endfunction

	logic signed [SIN_W-1:0] rom [DEPTH];

	for (genvar k = 0; k < DEPTH; k++) begin : g_rom
		assign rom[k] = sine_entry(k);
	end

	always_ff @(posedge clk) begin
		data_a <= rom[addr_a];
		data_b <= rom[addr_b];
	end

endmodule

// ===== sv/srs_soft_clip.sv =====
// Five-stage soft clip: divide by ten, clamp to +-2 V and parabolic shaping.
// Depends on srs_pkg for the sample type and the rotated-sum width.
module srs_soft_clip import srs_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    valid_in,
	input  logic signed [ROT_W-1:0] t_in,
	output logic                    valid_out,
	output sample_t                 clip_out
);

	localparam logic signed [36:0] Q_LIM = 37'sd83886080;   // 5 * 2^24
	localparam logic [27:0] RECIP_5 = 28'd214748365;          // (2^30 + 1) / 5

	logic [4:0] valid_q;

	logic signed [36:0] q_full;
	logic signed [36:0] q_sat;
	logic [27:0] n_s1;
	logic [55:0] prod_s2;
	logic signed [25:0] c_s3;
	logic [24:0] ac_s3;
	logic signed [25:0] c_s4;
	logic signed [50:0] cac_s4;
	logic signed [51:0] diff;
	logic signed [55:0] num;
	logic signed [55:0] rnd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= {valid_q[3:0], valid_in};
		end
	end

	// The clamp on the quotient by 2^16 keeps floor(q/5) inside +-2^24.
	always_comb begin
		q_full = 37'((t_in + ROT_W'(163840)) >>> 16);
		if (q_full > Q_LIM) begin
			q_sat = Q_LIM;
		end else if (q_full < -Q_LIM) begin
			q_sat = -Q_LIM;
		end else begin
			q_sat = q_full;
		end
	end

	always_ff @(posedge clk) begin
		n_s1    <= 28'(q_sat + Q_LIM);
		prod_s2 <= 56'(n_s1) * 56'(RECIP_5);
		c_s3    <= 26'($signed({1'b0, prod_s2[55:30]}) - 27'sd16777216);
		ac_s3   <= 25'((prod_s2[55:30] >= 26'd16777216) ?
			prod_s2[55:30] - 26'd16777216 : 26'd16777216 - prod_s2[55:30]);
		c_s4    <= c_s3;
		cac_s4  <= 51'(c_s3 * $signed({1'b0, ac_s3}));
		clip_out <= 16'(rnd >>> 37);
	end

	always_comb begin
		diff = (52'(c_s4) <<< 25) - 52'(cac_s4);
		num  = 56'(diff) * 56'sd10;
		rnd  = num + (56'sd1 <<< 36);
	end

	assign valid_out = valid_q[4];

endmodule

// ===== sv/shear_rotate_saturate_2d.sv =====
// Top level of the shear, rotate and soft-clip block: registers, shear and
// rotation pipeline. Depends on srs_pkg, srs_sine_rom and srs_soft_clip.
//
// Channel     Signals                                         Direction
// command     start, busy, in_x, in_y, angle_cv,              in (busy out)
//             shear_x_cv, shear_y_cv
// result      done, out_x, out_y                              out
// config      wr_en, wr_index, wr_data                        in
//
// Each word passes through seven stages of offset, shear, phase, lookup and
// rotation, then five in the soft clip.
// One word is accepted in every cycle; busy is always low.
// Reset clears the configuration registers and the valid bits only.
// The result is shown for one cycle with done high; the receiver cannot stall.
module shear_rotate_saturate_2d import srs_pkg::*; #(
	parameter int SINE_TABLE_DEPTH = 256,
	parameter int POST_X_OFFSET = 0,
	parameter int POST_Y_OFFSET = 0
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  sample_t     in_x,
	input  sample_t     in_y,
	input  sample_t     angle_cv,
	input  sample_t     shear_x_cv,
	input  sample_t     shear_y_cv,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [15:0] wr_data,
	output logic        done,
	output sample_t     out_x,
	output sample_t     out_y
);

	localparam int AW = $clog2(SINE_TABLE_DEPTH);
	localparam int PW = 16 + AW + 1;
	localparam logic [PW-1:0] DEPTH_P = PW'(SINE_TABLE_DEPTH);
	localparam logic signed [ROT_W-1:0] POST_X_T =
		ROT_W'(longint'(POST_X_OFFSET) * 64'sd134217728);
	localparam logic signed [ROT_W-1:0] POST_Y_T =
		ROT_W'(longint'(POST_Y_OFFSET) * 64'sd134217728);
	localparam logic [23:0] RECIP_5 = 24'd13421773;          // ceil(2^26 / 5)
	localparam logic [22:0] ANGLE_BIAS = 23'd5242880;        // 5 * 2^20

	// Configuration registers.
	sample_t cfg_q [8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				cfg_q[i] <= '0;
			end
		end else if (wr_en) begin
			cfg_q[wr_index] <= wr_data;
		end
	end

	// The pipeline never stalls, so the block always takes a word.
	assign busy = 1'b0;

	logic [6:0] valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= {valid_q[5:0], start};
		end
	end

	// Stage 1: pre-offsets and the three control products.
	logic signed [16:0] x_s1, y_s1;
	logic signed [31:0] pa_s1, psx_s1, psy_s1;

	always_ff @(posedge clk) begin
		x_s1   <= 17'(in_x) + 17'(cfg_q[REG_PRE_X_OFFSET]);
		y_s1   <= 17'(in_y) + 17'(cfg_q[REG_PRE_Y_OFFSET]);
		pa_s1  <= angle_cv * cfg_q[REG_ANGLE_CV_GAIN];
		psx_s1 <= shear_x_cv * cfg_q[REG_SHEAR_X_CV_GAIN];
		psy_s1 <= shear_y_cv * cfg_q[REG_SHEAR_Y_CV_GAIN];
	end

	// Stage 2: saturated shear coefficients, and the angle quotient by 1024
	// multiplied by the reciprocal of five to finish the division by 5120.
	function automatic logic signed [16:0] shear_sat(input sample_t base,
			input logic signed [31:0] prod);
		logic signed [20:0] k;
		k = 21'(base) + 21'((33'(prod) + 33'sd2048) >>> 12);
		if (k > 21'sd65535) begin
			k = 21'sd65535;
		end else if (k < -21'sd65536) begin
			k = -21'sd65536;
		end
		return 17'(k);
	endfunction

	// The quotient by 1024 lies within +-2^20, so the bias keeps it positive
	// and the reciprocal multiply works on an unsigned value.
	logic [22:0] qa;
	logic signed [16:0] x_s2, y_s2, kx_s2, ky_s2;
	logic [46:0] adiv_s2;

	assign qa = 23'((33'(pa_s1) + 33'sd2560) >>> 10) + ANGLE_BIAS;

	always_ff @(posedge clk) begin
		x_s2    <= x_s1;
		y_s2    <= y_s1;
		kx_s2   <= shear_sat(cfg_q[REG_SHEAR_X_BASE], psx_s1);
		ky_s2   <= shear_sat(cfg_q[REG_SHEAR_Y_BASE], psy_s1);
		adiv_s2 <= 47'(qa) * 47'(RECIP_5);
	end

	// Stage 3: phase for sine and cosine, and the cross-shear products.
	logic signed [21:0] delta;
	logic [15:0] ph_s_s3, ph_c_s3;
	logic signed [16:0] x_s3, y_s3;
	logic signed [33:0] ykx_s3, xky_s3;

	assign delta = 22'($signed({1'b0, adiv_s2[46:26]}) - 22'sd1048576);

	always_ff @(posedge clk) begin
		ph_s_s3 <= 16'(22'(cfg_q[REG_ANGLE_BASE]) + delta);
		ph_c_s3 <= 16'(22'(cfg_q[REG_ANGLE_BASE]) + delta + 22'sd16384);
		x_s3    <= x_s2;
		y_s3    <= y_s2;
		ykx_s3  <= y_s2 * kx_s2;
		xky_s3  <= x_s2 * ky_s2;
	end

	// Stage 4: table addresses, rounded and wrapped, and the sheared pair.
	function automatic logic [AW-1:0] tab_addr(input logic [15:0] ph);
		logic [PW-1:0] p;
		logic [AW:0] idx;
		p = PW'(ph) * DEPTH_P + PW'(32768);
		idx = (AW + 1)'(p >> 16);
		if (idx >= (AW + 1)'(SINE_TABLE_DEPTH)) begin
			idx = idx - (AW + 1)'(SINE_TABLE_DEPTH);
		end
		return idx[AW-1:0];
	endfunction

	logic [AW-1:0] addr_s_s4, addr_c_s4;
	logic signed [34:0] u_s4, v_s4;

	always_ff @(posedge clk) begin
		addr_s_s4 <= tab_addr(ph_s_s3);
		addr_c_s4 <= tab_addr(ph_c_s3);
		u_s4      <= (35'(x_s3) <<< 13) + 35'(ykx_s3);
		v_s4      <= (35'(y_s3) <<< 13) + 35'(xky_s3);
	end

	// Stage 5: sine and cosine come out of the registered lookup.
	logic signed [SIN_W-1:0] sin_s5, cos_s5;
	logic signed [34:0] u_s5, v_s5;

	srs_sine_rom #(
		.DEPTH(SINE_TABLE_DEPTH)
	) u_rom (
		.clk   (clk),
		.addr_a(addr_s_s4),
		.addr_b(addr_c_s4),
		.data_a(sin_s5),
		.data_b(cos_s5)
	);

	always_ff @(posedge clk) begin
		u_s5 <= u_s4;
		v_s5 <= v_s4;
	end

	// Stage 6: the four rotation products.
	logic signed [50:0] cu_s6, sv_s6, cv_s6, su_s6;

	always_ff @(posedge clk) begin
		cu_s6 <= cos_s5 * u_s5;
		sv_s6 <= sin_s5 * v_s5;
		cv_s6 <= cos_s5 * v_s5;
		su_s6 <= sin_s5 * u_s5;
	end

	// Stage 7: rotated sums with the post-offsets, exact in LSB * 2^27.
	logic signed [ROT_W-1:0] tx_s7, ty_s7;

	always_ff @(posedge clk) begin
		tx_s7 <= ROT_W'(cu_s6) + ROT_W'(sv_s6) + POST_X_T;
		ty_s7 <= ROT_W'(cv_s6) - ROT_W'(su_s6) + POST_Y_T;
	end

	// Stages 8 to 12: one soft clip per axis. Both axes run in lockstep.
	logic done_x;
	logic done_y;

	srs_soft_clip u_clip_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_in (valid_q[6]),
		.t_in     (tx_s7),
		.valid_out(done_x),
		.clip_out (out_x)
	);

	srs_soft_clip u_clip_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_in (valid_q[6]),
		.t_in     (ty_s7),
		.valid_out(done_y),
		.clip_out (out_y)
	);

	assign done = done_x & done_y;

endmodule

// ===== bench/tb_shear_rotate_saturate_2d.sv =====
// Self-checking bench for shear_rotate_saturate_2d: directed and random words,
// predicted in-bench. Depends on srs_pkg and the block under test.
`timescale 1ns / 1ps

module tb_shear_rotate_saturate_2d import srs_pkg::*;;

	localparam int TABLE_DEPTH = 256;
	localparam longint PIHALF_Q30 = 64'd1686629713;
	localparam int LATENCY = 12;
	localparam int WATCHDOG_LIMIT = 2000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	sample_t     in_x = '0, in_y = '0, angle_cv = '0, shear_x_cv = '0, shear_y_cv = '0;
	logic        wr_en = 1'b0;
	logic [2:0]  wr_index = '0;
	logic [15:0] wr_data = '0;
	logic        done;
	sample_t     out_x, out_y;

	shear_rotate_saturate_2d dut (.*);

	always #5 clk = ~clk;

	// Bench copy of the configuration registers and the sine table.
	longint cfg [8];
	longint sine_q14 [TABLE_DEPTH];

	typedef struct packed {
		sample_t x;
		sample_t y;
	} pair_t;
	pair_t expected_pairs [$];

	int mismatches = 0;
	int words_sent = 0;
	int pairs_checked = 0;
	int idle_pct = 20;
	int quiet_cycles = 0;

	function automatic longint fdiv(longint a, longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && a < 0)
			q--;
		return q;
	endfunction

	function automatic void fill_sine();
		longint unsigned a, quad, r, x, x2, term;
		longint sum, mag;
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			a = 4 * k;
			quad = a / TABLE_DEPTH;
			r = a % TABLE_DEPTH;
			if (quad[0])
				r = TABLE_DEPTH - r;
			x = r * PIHALF_Q30 / TABLE_DEPTH;
			x2 = (x * x) >> 30;
			term = x;
			sum = x;
			for (int n = 1; n <= 5; n++) begin
				term = (term * x2) >> 30;
				term = term / ((2 * n) * (2 * n + 1));
				if (n % 2)
					sum -= term;
				else
					sum += term;
			end
			if (sum < 0)
				sum = 0;
			mag = (sum + 32768) / 65536;
			if (mag > 16384)
				mag = 16384;
			sine_q14[k] = (quad >= 2) ? -mag : mag;
		end
	endfunction

	function automatic longint sine_of(longint phase);
		longint idx;
		idx = ((phase & 64'hFFFF) * TABLE_DEPTH + 32768) >>> 16;
		if (idx >= TABLE_DEPTH)
			idx -= TABLE_DEPTH;
		return sine_q14[idx];
	endfunction

	function automatic longint shear_coef(longint base, longint cv, longint gain);
		longint k;
		k = base + fdiv(cv * gain + 2048, 4096);
		if (k > 65535)
			k = 65535;
		if (k < -65536)
			k = -65536;
		return k;
	endfunction

	function automatic sample_t soft_clip(longint t);
		longint lim, c, ac, num;
		lim = 4096 * 4096;
		c = fdiv(t + 5 * 32768, 10 * 32768);
		if (c > lim)
			c = lim;
		if (c < -lim)
			c = -lim;
		ac = (c < 0) ? -c : c;
		num = 10 * c * 33554432 - 10 * c * ac;
		return sample_t'(fdiv(num + (64'sd1 <<< 36), 64'sd1 <<< 37));
	endfunction

	// Transform of one word: offsets, cross-shear, rotation and clip.
	function automatic pair_t transform(sample_t ix, sample_t iy, sample_t acv,
			sample_t sxcv, sample_t sycv);
		longint x, y, kx, ky, u, v, s, c, tx, ty, delta, phase;
		pair_t p;
		x = longint'(ix) + cfg[REG_PRE_X_OFFSET];
		y = longint'(iy) + cfg[REG_PRE_Y_OFFSET];
		delta = fdiv(longint'(acv) * cfg[REG_ANGLE_CV_GAIN] + 2560, 5120);
		phase = (cfg[REG_ANGLE_BASE] + delta) & 64'hFFFF;
		s = sine_of(phase);
		c = sine_of(phase + 16384);
		kx = shear_coef(cfg[REG_SHEAR_X_BASE], sxcv, cfg[REG_SHEAR_X_CV_GAIN]);
		ky = shear_coef(cfg[REG_SHEAR_Y_BASE], sycv, cfg[REG_SHEAR_Y_CV_GAIN]);
		u = x * 8192 + y * kx;
		v = y * 8192 + x * ky;
		tx = c * u + s * v;
		ty = c * v - s * u;
		p.x = soft_clip(tx);
		p.y = soft_clip(ty);
		return p;
	endfunction

	// Sends one word, with a random idle gap ahead of it, and queues its prediction.
	// start stays high after the accepting edge so that words can follow back to back.
	task automatic send_word(sample_t ix, sample_t iy, sample_t acv, sample_t sxcv,
			sample_t sycv);
		wr_en <= 1'b0;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		in_x <= ix;
		in_y <= iy;
		angle_cv <= acv;
		shear_x_cv <= sxcv;
		shear_y_cv <= sycv;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		expected_pairs.push_back(transform(ix, iy, acv, sxcv, sycv));
		words_sent++;
	endtask

	// Waits for every pending result, then lets the pipeline drain before a write.
	task automatic drain();
		start <= 1'b0;
		while (expected_pairs.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// Writes one register; the next word sent lowers the write enable.
	task automatic write_reg(reg_index_t idx, logic [15:0] value);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		@(posedge clk);
		cfg[idx] = longint'($signed(value));
	endtask

	function automatic sample_t rand_sample();
		case ($urandom_range(5))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return sample_t'($urandom_range(4095)) - 16'sd2048;
			default: return sample_t'($urandom);
		endcase
	endfunction

	task automatic send_random(int count);
		for (int i = 0; i < count; i++)
			send_word(rand_sample(), rand_sample(), rand_sample(), rand_sample(),
				rand_sample());
	endtask

	// Identity transform with full-scale inputs: exercises the clip knee.
	task automatic test_identity_extremes();
		sample_t edges [5] = '{16'sh7FFF, 16'sh8000, 16'sd0, 16'sd1, -16'sd1};
		foreach (edges[i])
			foreach (edges[j])
				send_word(edges[i], edges[j], edges[(i + j) % 5], edges[j], edges[i]);
	endtask

	// Extreme registers: shear saturation and a wrapped phase.
	task automatic test_register_extremes();
		drain();
		write_reg(REG_ANGLE_BASE, 16'h7FFF);
		write_reg(REG_ANGLE_CV_GAIN, 16'h4000);
		write_reg(REG_SHEAR_X_BASE, 16'h6000);
		write_reg(REG_SHEAR_X_CV_GAIN, 16'h4000);
		write_reg(REG_SHEAR_Y_BASE, 16'hA000);
		write_reg(REG_SHEAR_Y_CV_GAIN, 16'hC000);
		write_reg(REG_PRE_X_OFFSET, 16'h5000);
		write_reg(REG_PRE_Y_OFFSET, 16'hB000);
		send_word(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
		send_word(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF);
		send_word(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
		send_word(16'sd100, -16'sd100, 16'sd2048, 16'sd0, 16'sd0);
		drain();
		foreach (cfg[r])
			write_reg(reg_index_t'(r), 16'hFFFF);
		send_word(16'sd2048, 16'sd2048, 16'sd0, 16'sd0, 16'sd0);
	endtask

	// Random words across several random register settings, small and raw.
	task automatic test_random_settings();
		for (int phase = 0; phase < 12; phase++) begin
			drain();
			foreach (cfg[r])
				write_reg(reg_index_t'(r), (phase % 3 == 0) ? 16'($urandom_range(8191)
					- 4096) : 16'($urandom));
			// One phase runs without idle gaps.
			idle_pct = (phase == 5) ? 0 : 20;
			send_random(150);
		end
		idle_pct = 20;
	endtask

	// Result checker: done cannot be held off, so every strobe is a result.
	always @(posedge clk) begin
		pair_t exp_p;
		if (arst_n && done) begin
			if (expected_pairs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result word x=%0d y=%0d", out_x, out_y);
			end else begin
				exp_p = expected_pairs.pop_front();
				pairs_checked++;
				if (out_x !== exp_p.x || out_y !== exp_p.y) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
							exp_p.x, exp_p.y, out_x, out_y);
				end
			end
		end
	end

	// Watchdog on cycles where no word is taken, no result comes back and no register is written.
	always @(posedge clk) begin
		if ((start && !busy) || done || wr_en)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		foreach (cfg[r])
			cfg[r] = 0;
		fill_sine();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_identity_extremes();
		test_register_extremes();
		test_random_settings();
		drain();
		$display("Sent %0d words over 15 register settings; checked %0d results.",
			words_sent, pairs_checked);
		if (mismatches == 0 && expected_pairs.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/srs_pkg.sv
sv/srs_sine_rom.sv
sv/srs_soft_clip.sv
sv/shear_rotate_saturate_2d.sv
bench/tb_shear_rotate_saturate_2d.sv
